FILE: design/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenOffset = 6'd56;

	typedef struct packed {
		logic [511:0] data;
		logic         last;
	} blk_t;

	typedef logic [31:0] word_t;

	function automatic word_t iv_word(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] i);
		word_t r;
		unique case (i)
			6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491;
			6'd2: r = 32'hb5c0fbcf; 6'd3: r = 32'he9b5dba5;
			6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5;
			6'd8: r = 32'hd807aa98; 6'd9: r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Byte packer, bit counter and padding sequencer; emits 512-bit blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front
	import sha_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       data_valid,
	output logic            data_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       has_byte,
	input  wire logic       end_of_message,
	output logic            push,
	output blk_t            push_blk,
	input  wire logic       full
);

	typedef enum logic [1:0] {ST_ACCEPT, ST_PAD80, ST_ZERO, ST_LEN} state_t;

	state_t       state_q;
	logic [511:0] buf_q;
	logic [5:0]   fill_q;
	logic [63:0]  count_q;
	logic [63:0]  len_q;
	logic [2:0]   lidx_q;

	logic         can_wr;
	logic         wr;
	logic [7:0]   wbyte;
	logic [511:0] buf_nx;
	logic         acc;

	assign can_wr     = (fill_q != 6'd63) || !full;
	assign data_ready = (state_q == ST_ACCEPT) && can_wr;
	assign acc        = data_valid && data_ready;

	always_comb begin
		wr    = 1'b0;
		wbyte = 8'h00;
		unique case (state_q)
			ST_ACCEPT: begin
				wr    = acc && has_byte;
				wbyte = data_byte;
			end
			ST_PAD80: begin
				wr    = can_wr;
				wbyte = PadByte;
			end
			ST_ZERO: begin
				wr    = can_wr && (fill_q != LenOffset);
				wbyte = 8'h00;
			end
			ST_LEN: begin
				wr    = can_wr;
				wbyte = len_q[63:56];
			end
		endcase
		buf_nx = buf_q;
		buf_nx[{~fill_q, 3'b000} +: 8] = wbyte;
	end

	assign push          = wr && (fill_q == 6'd63);
	assign push_blk.data = buf_nx;
	assign push_blk.last = (state_q == ST_LEN) && (lidx_q == 3'd7);

	always_ff @(posedge clk) begin
		if (wr) buf_q <= buf_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
			fill_q  <= '0;
			count_q <= '0;
			len_q   <= '0;
			lidx_q  <= '0;
		end else begin
			if (wr) fill_q <= fill_q + 6'd1;
			unique case (state_q)
				ST_ACCEPT: begin
					if (acc) begin
						if (has_byte) count_q <= count_q + 64'd8;
						if (end_of_message) begin
							len_q   <= has_byte ? count_q + 64'd8 : count_q;
							state_q <= ST_PAD80;
						end
					end
				end
				ST_PAD80: begin
					if (wr) state_q <= ST_ZERO;
				end
				ST_ZERO: begin
					if (fill_q == LenOffset) begin
						state_q <= ST_LEN;
						lidx_q  <= '0;
					end
				end
				ST_LEN: begin
					if (wr) begin
						len_q  <= {len_q[55:0], 8'h00};
						lidx_q <= lidx_q + 3'd1;
						if (lidx_q == 3'd7) begin
							count_q <= '0;
							state_q <= ST_ACCEPT;
						end
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/sha_fifo.sv
// ----------------------------------------------------------------------------
// sha_fifo
// Two-entry block queue between the front and the compression core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_fifo
	import sha_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  blk_t      push_blk,
	output logic      full,
	input  wire logic pop,
	output blk_t      pop_blk,
	output logic      empty
);

	blk_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign pop_blk = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_blk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// One-round-per-cycle compression core with digest output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_back
	import sha_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         empty,
	input  blk_t              pop_blk,
	output logic              pop,
	output logic              digest_valid,
	input  wire logic         digest_ready,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);

	typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL} state_t;

	state_t     state_q;
	word_t      w_q [16];
	word_t      v_q [8];
	word_t      h_q [8];
	word_t      dig_q [8];
	logic       last_q;
	logic [5:0] rnd_q;
	logic       ov_q;
	logic [2:0] oidx_q;

	word_t s0, s1, wnew, b1, ch, t1, b0, mj;
	logic  out_acc;
	logic  fin_go;

	assign out_acc = ov_q && digest_ready;
	assign pop     = (state_q == ST_IDLE) && !empty;
	assign fin_go  = (state_q == ST_FINAL) && !(last_q && ov_q);

	always_comb begin
		s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]}
			^ (w_q[1] >> 3);
		s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		wnew = s1 + w_q[9] + s0 + w_q[0];
		b1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]};
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + b1 + ch + round_k(rnd_q) + w_q[0];
		b0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]};
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < 16; i++) w_q[i] <= pop_blk.data[511 - 32 * i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			last_q <= pop_blk.last;
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wnew;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + b0 + mj;
		end
		if (fin_go && last_q) begin
			for (int i = 0; i < 8; i++) dig_q[i] <= h_q[i] + v_q[i];
		end else if (out_acc) begin
			for (int i = 0; i < 7; i++) dig_q[i] <= dig_q[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			ov_q    <= 1'b0;
			oidx_q  <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= iv_word(3'(i));
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					if (fin_go) begin
						for (int i = 0; i < 8; i++) begin
							h_q[i] <= last_q ? iv_word(3'(i)) : h_q[i] + v_q[i];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fin_go && last_q) begin
				ov_q   <= 1'b1;
				oidx_q <= '0;
			end else if (out_acc) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) ov_q <= 1'b0;
			end
		end
	end

	assign digest_valid = ov_q;
	assign digest_word  = dig_q[0];
	assign word_index   = oidx_q;
	assign last_word    = (oidx_q == 3'd7);

endmodule

`default_nettype wire

FILE: design/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// Streaming SHA-256: bytes in, eight 32-bit digest words out per message.
// ----------------------------------------------------------------------------
// Input channel (data_valid/data_ready): each request carries data_byte with
// has_byte, and end_of_message. One byte is taken per cycle while data_ready
// is high; while accepting, the front only holds off when a 64-byte block
// completes while the two-entry block queue is full. After an end request
// the front writes the 0x80 byte, zero fill and the 8-byte length with
// data_ready low, pausing while a completed block waits for queue room.
// In the core each block goes through load, 64 rounds (one round per cycle
// of the single round unit) and final add. Sustained input rate is about
// one byte per cycle while the queue has room; the core runs beside the front.
// Output channel (digest_valid/digest_ready): eight requests, word 0 first,
// from a registered digest buffer, loaded at the final add after the last
// round of the final block. A stalled receiver holds the current word; the
// core keeps working on queued blocks and only waits if the next message's
// digest is ready before the previous one is drained.
// Reset clears the byte counter, queue and state, and loads the initial
// hash values.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_unit
	import sha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        data_valid,
	output logic             data_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        end_of_message,
	output logic             digest_valid,
	input  wire logic        digest_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	logic push, pop, full, empty;
	blk_t push_blk, pop_blk;

	sha_front u_front (
		.clk, .arst_n, .data_valid, .data_ready, .data_byte, .has_byte,
		.end_of_message, .push, .push_blk, .full
	);

	sha_fifo u_fifo (
		.clk, .arst_n, .push, .push_blk, .full, .pop, .pop_blk, .empty
	);

	sha_back u_back (
		.clk, .arst_n, .empty, .pop_blk, .pop, .digest_valid, .digest_ready,
		.digest_word, .word_index, .last_word
	);

endmodule

`default_nettype wire

FILE: design/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the digest channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        digest_valid,
	input wire logic        digest_ready,
	input wire logic [31:0] digest_word,
	input wire logic [2:0]  word_index,
	input wire logic        last_word
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_ready |=> digest_valid && $stable(digest_word)
		&& $stable(word_index))
		else $error("digest request dropped or changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word does not match word 7");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && !last_word |=>
		digest_valid && word_index == 3'($past(word_index) + 3'd1))
		else $error("digest words out of sequence");

endmodule

bind sha256_stream_hasher_unit sha_checker u_sha_checker (
	.clk, .arst_n, .digest_valid, .digest_ready, .digest_word, .word_index,
	.last_word
);

`default_nettype wire

FILE: tb/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels of the SHA-256 hasher, computes the digest of each
// message from the accepted byte requests and compares every digest word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sha256_digest_checker
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	input  logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	input  logic        digest_valid,
	input  logic        digest_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          pending_words,
	output int          digests_seen
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_exp_t;

	logic [31:0] chain[8];
	logic [7:0]  blk_bytes[64];
	logic [5:0]  fill;
	logic [63:0] msg_bits;
	digest_exp_t digest_q[$];

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] init_word(input int i);
		logic [31:0] iv[8];
		iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return iv[i];
	endfunction

	task automatic compress();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2],
				blk_bytes[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endtask

	task automatic append_byte(input logic [7:0] b);
		blk_bytes[fill] = b;
		fill++;
		if (fill == 6'd0)
			compress();
	endtask

	task automatic restart();
		for (int i = 0; i < 8; i++)
			chain[i] = init_word(i);
		msg_bits = '0;
		fill = '0;
	endtask

	task automatic absorb_request(input logic [7:0] b, input logic hb, input logic eom);
		logic [63:0] len;
		if (hb) begin
			append_byte(b);
			msg_bits += 64'd8;
		end
		if (eom) begin
			len = msg_bits;
			append_byte(PadByte);
			while (fill != LenOffset)
				append_byte(8'h00);
			for (int i = 0; i < 8; i++)
				append_byte(len[63-8*i -: 8]);
			for (int i = 0; i < 8; i++)
				digest_q.push_back('{chain[i], 3'(i), i == 7});
			restart();
		end
	endtask

	initial begin
		fail_count = 0;
		digests_seen = 0;
		pending_words = 0;
		restart();
	end

	always @(posedge clk) begin
		digest_exp_t e;
		if (arst_n) begin
			if (data_valid && data_ready)
				absorb_request(data_byte, has_byte, end_of_message);
			if (digest_valid && digest_ready) begin
				if (digest_q.size() == 0) begin
					$display("%t: unexpected digest word: actual %h idx %0d last %b",
						$realtime, digest_word, word_index, last_word);
					fail_count++;
				end else begin
					e = digest_q.pop_front();
					if (digest_word !== e.word || word_index !== e.idx
						|| last_word !== e.last) begin
						$display("%t: digest mismatch: expected %h idx %0d last %b,",
							$realtime, e.word, e.idx, e.last);
						$display("    actual %h idx %0d last %b",
							digest_word, word_index, last_word);
						fail_count++;
					end
					if (e.last)
						digests_seen++;
				end
			end
			pending_words = digest_q.size();
		end
	end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the SHA-256 hasher testbench: sends directed and random messages
// with random gaps and digest stalls, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	localparam int IdleLimit = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_ready;
	logic [7:0]  data_byte = '0;
	logic        has_byte = 1'b0;
	logic        end_of_message = 1'b0;
	logic        digest_valid;
	logic        digest_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count, pending_words, digests_seen;
	int          idle_cycles = 0;
	int          requests_sent = 0;
	bit          calm = 1'b0;

	sha256_stream_hasher_unit uut (
		.clk(clk), .arst_n(arst_n),
		.data_valid(data_valid), .data_ready(data_ready),
		.data_byte(data_byte), .has_byte(has_byte), .end_of_message(end_of_message),
		.digest_valid(digest_valid), .digest_ready(digest_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	sha256_digest_checker chk (
		.clk(clk), .arst_n(arst_n),
		.data_valid(data_valid), .data_ready(data_ready),
		.data_byte(data_byte), .has_byte(has_byte), .end_of_message(end_of_message),
		.digest_valid(digest_valid), .digest_ready(digest_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word),
		.fail_count(fail_count), .pending_words(pending_words), .digests_seen(digests_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk)
		digest_ready <= calm || ($urandom_range(99) >= 33);

	always @(posedge clk) begin
		if ((data_valid && data_ready) || (digest_valid && digest_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("watchdog expired at %t", $realtime);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_request(input logic [7:0] b, input logic hb, input logic eom);
		while (!calm && $urandom_range(99) < 33) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		has_byte <= hb;
		end_of_message <= eom;
		@(posedge clk);
		while (!data_ready)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic send_message(input int len, input bit empty_end, input logic [7:0] fillv,
		input bit rnd);
		for (int i = 0; i < len; i++)
			send_request(rnd ? 8'($urandom) : fillv, 1'b1,
				!empty_end && i == len - 1);
		if (empty_end || len == 0)
			send_request(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty message, idle items, extremes
		send_message(0, 1'b1, 8'h00, 1'b0);
		send_request(8'hff, 1'b0, 1'b0);
		send_request(8'h00, 1'b0, 1'b0);
		send_message(1, 1'b0, 8'h00, 1'b0);
		send_message(1, 1'b0, 8'hff, 1'b0);
		send_message(3, 1'b0, 8'h61, 1'b0);
		send_message(2, 1'b1, 8'haa, 1'b0);
		send_message(2, 1'b0, 8'h55, 1'b0);
		send_message(6, 1'b0, 8'h00, 1'b1);
		// padding boundary at 56 bytes, then random: mostly short messages, a few across block and pad limits
		calm = 1'b1;
		send_message(56, 1'b0, 8'h00, 1'b1);
		calm = 1'b0;
		while (requests_sent < 180) begin
			int len;
			case ($urandom_range(9))
				0: len = $urandom_range(54, 66);
				1: len = 64;
				2: len = $urandom_range(120, 130);
				default: len = $urandom_range(0, 12);
			endcase
			if (len > 185 - requests_sent)
				len = 185 - requests_sent;
			if ($urandom_range(3) == 0)
				send_request(8'($urandom), 1'b0, 1'b0);
			send_message(len, $urandom_range(3) == 0, 8'h00, 1'b1);
		end
		data_valid <= 1'b0;
		while (pending_words != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d requests and %0d digests,", requests_sent, digests_seen);
		$display("with empty, block-edge and multi-block messages");
		if (fail_count == 0 && pending_words == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sha256_stream_hasher_unit.f
design/sha_pkg.sv
design/sha_front.sv
design/sha_fifo.sv
design/sha_back.sv
design/sha256_stream_hasher_unit.sv
design/sha_checker.sv
tb/sha256_digest_checker.sv
tb/tb.sv
